>>> design/counter_based_random_word_assert.svh
// assertion macros for the counter based random word design
`ifndef COUNTER_BASED_RANDOM_WORD_ASSERT_SVH
`define COUNTER_BASED_RANDOM_WORD_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define CRW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crw assertion failed");

// next-cycle implication
`define CRW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crw assertion failed");

`endif

>>> design/crw_pkg.sv
// types, constants and mixing functions of the counter based random word block
`timescale 1ns / 1ps

package crw_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumWords = 6;
  localparam int unsigned CtrW     = 64;
  localparam int unsigned CfgIdxW  = 3;

  typedef logic [WordW-1:0] word_t;
  typedef logic [NumWords-1:0][WordW-1:0] state_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgKey0 = 3'd0,
    CfgKey1 = 3'd1,
    CfgKey2 = 3'd2,
    CfgKey3 = 3'd3,
    CfgKey4 = 3'd4,
    CfgKey5 = 3'd5
  } cfg_idx_e;

  // one third of the mixing round per pipeline stage
  typedef enum logic [1:0] {
    PhaseA,
    PhaseB,
    PhaseC
  } phase_e;

  localparam int unsigned Rot7  = 7;
  localparam int unsigned Rot9  = 9;
  localparam int unsigned Rot12 = 12;
  localparam int unsigned Rot13 = 13;
  localparam int unsigned Rot18 = 18;

  function automatic word_t rotl(word_t x, int unsigned s);
    return (x << s) | (x >> (WordW - s));
  endfunction

  function automatic word_t add_sub(word_t a, word_t b, logic sub);
    return sub ? word_t'(a - b) : word_t'(a + b);
  endfunction

  // nine steps of one phase of the round: three rotations, three add/subtract, three xor chains
  function automatic state_t mix_phase(state_t s, phase_e ph);
    state_t      w;
    int unsigned r0;
    int unsigned r2;
    int unsigned r4;
    logic        sub1;
    logic        sub3;
    logic        sub5;
    w = s;
    case (ph)
      PhaseA: begin
        r0 = Rot7;  r2 = Rot9;  r4 = Rot13;
        sub1 = 1'b1; sub3 = 1'b0; sub5 = 1'b0;
      end
      PhaseB: begin
        r0 = Rot18; r2 = Rot7;  r4 = Rot9;
        sub1 = 1'b0; sub3 = 1'b1; sub5 = 1'b0;
      end
      default: begin
        r0 = Rot13; r2 = Rot18; r4 = Rot12;
        sub1 = 1'b0; sub3 = 1'b0; sub5 = 1'b1;
      end
    endcase
    w[0] = rotl(w[0], r0);
    w[1] = add_sub(w[1], w[0], sub1);
    w[2] = rotl(w[2] ^ w[1], r2);
    w[3] = add_sub(w[3], w[2], sub3);
    w[4] = rotl(w[4] ^ w[3], r4);
    w[5] = add_sub(w[5], w[4], sub5);
    w[0] = w[0] ^ w[5];
    return w;
  endfunction

endpackage

>>> design/crw_load.sv
// key registers and first pipeline stage: key load and counter injection
`timescale 1ns / 1ps

module crw_load (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [crw_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [crw_pkg::WordW-1:0]           cfg_wdata_i,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [crw_pkg::CtrW-1:0]            counter_value_i,
  input  logic                                last_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output crw_pkg::state_t                     state_o,
  output logic                                last_o
);

  crw_pkg::word_t  key_q [crw_pkg::NumWords];
  crw_pkg::state_t state_d;
  crw_pkg::state_t state_q;
  crw_pkg::word_t  ctr_lo;
  crw_pkg::word_t  ctr_hi;
  logic            valid_q;
  logic            last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < crw_pkg::NumWords; i++) begin
        key_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        crw_pkg::CfgKey0: key_q[0] <= cfg_wdata_i;
        crw_pkg::CfgKey1: key_q[1] <= cfg_wdata_i;
        crw_pkg::CfgKey2: key_q[2] <= cfg_wdata_i;
        crw_pkg::CfgKey3: key_q[3] <= cfg_wdata_i;
        crw_pkg::CfgKey4: key_q[4] <= cfg_wdata_i;
        crw_pkg::CfgKey5: key_q[5] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign ctr_lo = counter_value_i[crw_pkg::WordW-1:0];
  assign ctr_hi = counter_value_i[crw_pkg::CtrW-1:crw_pkg::WordW];

  always_comb begin
    state_d[0] = crw_pkg::word_t'(key_q[0] + ctr_lo);
    state_d[1] = key_q[1] ^ ctr_lo;
    state_d[2] = crw_pkg::word_t'(key_q[2] + ctr_hi);
    state_d[3] = key_q[3] ^ ctr_hi;
    state_d[4] = key_q[4];
    state_d[5] = key_q[5];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      state_q <= state_d;
      last_q  <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign last_o  = last_q;

endmodule

>>> design/crw_stage.sv
// one mixing pipeline stage: a third of the round and its register
`timescale 1ns / 1ps

module crw_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  crw_pkg::phase_e phase_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  crw_pkg::state_t state_i,
  input  logic            last_i,
  output logic            valid_o,
  input  logic            ready_i,
  output crw_pkg::state_t state_o,
  output logic            last_o
);

  crw_pkg::state_t state_d;
  crw_pkg::state_t state_q;
  logic            valid_q;
  logic            last_q;

  assign state_d = crw_pkg::mix_phase(state_i, phase_i);

  // the register may take a new transfer when empty or when it drains this cycle
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      state_q <= state_d;
      last_q  <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign last_o  = last_q;

endmodule

>>> design/counter_based_random_word.sv
// Counter based random word generator. Each transfer on the input side carries a
// 64-bit counter and yields one 32-bit word mixed from the six key words written over
// the configuration port (indexes 0 to 5; other indexes are ignored), together with
// a copy of the last flag. Unless stalled, the pipeline takes one counter per cycle
// and delivers one word per cycle; each word passes through five registers: one stage
// for key load and counter injection (filled at the edge that takes its counter),
// three stages of the mixing round (three dependent 32-bit add or subtract steps
// each) and the output register. Stalls back up stage by stage without loss. Write
// the key only while no transfer is in flight.
`timescale 1ns / 1ps

module counter_based_random_word (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [crw_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [crw_pkg::WordW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [crw_pkg::CtrW-1:0]    counter_value_i,
  input  logic                        last_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [crw_pkg::WordW-1:0]   random_word_o,
  output logic                        last_out_o
);

  `include "counter_based_random_word_assert.svh"

  localparam int unsigned NumStages = 4;

  logic            valid [NumStages];
  logic            ready [NumStages+1];
  crw_pkg::state_t state [NumStages];
  logic            last  [NumStages];

  logic            out_valid_q;
  crw_pkg::word_t  word_q;
  logic            last_q;

  crw_load u_load (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .valid_i         (in_valid_i),
    .ready_o         (ready[0]),
    .counter_value_i (counter_value_i),
    .last_i          (last_in_i),
    .valid_o         (valid[0]),
    .ready_i         (ready[1]),
    .state_o         (state[0]),
    .last_o          (last[0])
  );

  crw_stage u_stage_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .phase_i (crw_pkg::PhaseA),
    .valid_i (valid[0]),
    .ready_o (ready[1]),
    .state_i (state[0]),
    .last_i  (last[0]),
    .valid_o (valid[1]),
    .ready_i (ready[2]),
    .state_o (state[1]),
    .last_o  (last[1])
  );

  crw_stage u_stage_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .phase_i (crw_pkg::PhaseB),
    .valid_i (valid[1]),
    .ready_o (ready[2]),
    .state_i (state[1]),
    .last_i  (last[1]),
    .valid_o (valid[2]),
    .ready_i (ready[3]),
    .state_o (state[2]),
    .last_o  (last[2])
  );

  crw_stage u_stage_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .phase_i (crw_pkg::PhaseC),
    .valid_i (valid[2]),
    .ready_o (ready[3]),
    .state_i (state[2]),
    .last_i  (last[2]),
    .valid_o (valid[3]),
    .ready_i (ready[4]),
    .state_o (state[3]),
    .last_o  (last[3])
  );

  // output register
  assign ready[4] = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready[4]) begin
      out_valid_q <= valid[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid[3] && ready[4]) begin
      word_q <= state[3][0] ^ state[3][3];
      last_q <= last[3];
    end
  end

  assign in_stall_o    = !ready[0];
  assign out_valid_o   = out_valid_q;
  assign random_word_o = word_q;
  assign last_out_o    = last_q;

  // the input stalls only when every register of the pipeline is occupied
  `CRW_ASSERT_NOW(a_stall_only_full, in_stall_o,
                  valid[0] && valid[1] && valid[2] && valid[3] && out_valid_q)
  // a drained output never backs up to the input
  `CRW_ASSERT_NOW(a_no_stall_when_drained, !out_stall_i, !in_stall_o)
  // a word leaving the last mixing stage lands in the output register
  `CRW_ASSERT_NEXT(a_last_stage_moves, valid[3] && ready[4], out_valid_q)
  // an accepted counter always occupies the first stage next cycle
  `CRW_ASSERT_NEXT(a_input_lands, in_valid_i && !in_stall_o, valid[0])

endmodule

>>> test/tb_counter_based_random_word.sv
// self-checking testbench for the counter based random word generator
`timescale 1ns / 1ps

module tb_counter_based_random_word;
  import crw_pkg::*;

  localparam logic [CfgIdxW-1:0] SpareIdx6 = 3'd6;
  localparam logic [CfgIdxW-1:0] SpareIdx7 = 3'd7;
  localparam int unsigned NumDirected   = 15;
  localparam int unsigned NumPhases     = 7;
  localparam int unsigned ItemsPerPhase = 105;
  localparam int unsigned LatencyCycles = 5;
  localparam int unsigned LongHold      = 80;
  localparam int unsigned QuietLimit    = 1000;
  localparam int unsigned MaxPrinted    = 50;

  typedef struct packed {
    word_t word;
    logic  last;
  } word_entry_t;

  typedef struct packed {
    logic [CtrW-1:0] counter;
    logic            last;
    logic            typed;
    word_t           word;
  } directed_row_t;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              cfg_we        = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx      = '0;
  word_t             cfg_wdata     = '0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [CtrW-1:0]   counter_value = '0;
  logic              last_in       = 1'b0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  word_t             random_word;
  logic              last_out;

  word_t             key_words [NumWords];
  word_entry_t       pending_words [$];
  int unsigned       mismatches   = 0;
  int unsigned       quiet_cycles = 0;
  bit                gaps_on      = 1'b1;
  bit                long_hold    = 1'b0;

  // key is zero after reset, so only the zero counter is obvious by hand
  directed_row_t directed_rows [NumDirected] = '{
    '{64'h0000_0000_0000_0000, 1'b0, 1'b1, 32'h0000_0000},
    '{64'h0000_0000_0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{64'h0000_0000_0000_0001, 1'b0, 1'b0, 32'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 32'h0},
    '{64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0, 32'h0},
    '{64'h8000_0000_0000_0000, 1'b1, 1'b0, 32'h0},
    '{64'h0000_0000_8000_0000, 1'b0, 1'b0, 32'h0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 32'h0},
    '{64'h5555_5555_5555_5555, 1'b1, 1'b0, 32'h0},
    // run across the 64-bit wrap
    '{64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0, 32'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{64'h0000_0000_0000_0000, 1'b1, 1'b0, 32'h0},
    // carry from the low word into the high word
    '{64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{64'h0000_0001_0000_0000, 1'b1, 1'b0, 32'h0}
  };

  counter_based_random_word uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .counter_value_i (counter_value),
    .last_in_i       (last_in),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .random_word_o   (random_word),
    .last_out_o      (last_out)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic word_t rol32(input word_t x, input int unsigned s);
    return (x << s) | (x >> (WordW - s));
  endfunction

  // key load, counter injection and one full mixing round
  function automatic word_t predict_word(input logic [CtrW-1:0] ctr);
    word_t w [NumWords];
    foreach (w[i]) w[i] = key_words[i];
    w[0] = w[0] + ctr[31:0];
    w[1] = w[1] ^ ctr[31:0];
    w[2] = w[2] + ctr[63:32];
    w[3] = w[3] ^ ctr[63:32];

    w[0] = rol32(w[0], 7);
    w[1] = w[1] - w[0];
    w[2] = rol32(w[2] ^ w[1], 9);
    w[3] = w[3] + w[2];
    w[4] = rol32(w[4] ^ w[3], 13);
    w[5] = w[5] + w[4];
    w[0] = w[0] ^ w[5];

    w[0] = rol32(w[0], 18);
    w[1] = w[1] + w[0];
    w[2] = rol32(w[2] ^ w[1], 7);
    w[3] = w[3] - w[2];
    w[4] = rol32(w[4] ^ w[3], 9);
    w[5] = w[5] + w[4];
    w[0] = w[0] ^ w[5];

    w[0] = rol32(w[0], 13);
    w[1] = w[1] + w[0];
    w[2] = rol32(w[2] ^ w[1], 18);
    w[3] = w[3] + w[2];
    w[4] = rol32(w[4] ^ w[3], 12);
    w[5] = w[5] - w[4];
    w[0] = w[0] ^ w[5];
    return w[0] ^ w[3];
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("mismatch at %0t ns: %s got %h expected %h", $time, what, got, want);
  endtask

  // caller lowers cfg_we after the last write of a batch
  task automatic write_key_reg(input logic [CfgIdxW-1:0] idx, input word_t data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    if (idx < NumWords) key_words[idx] = data;
  endtask

  // one input transfer; the expected word is queued at the accepting edge
  task automatic send_counter(input logic [CtrW-1:0] ctr, input logic last, input word_t want);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    counter_value <= ctr;
    last_in       <= last;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    pending_words.push_back('{word: want, last: last});
  endtask

  // mostly runs of consecutive counters ending in last, some lone counters as noise
  task automatic run_counters(input int unsigned count);
    logic [CtrW-1:0] start;
    int unsigned     run_len;
    int unsigned     sent;
    int unsigned     k;
    sent = 0;
    while (sent < count) begin
      start = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) begin
        send_counter(start, 1'($urandom_range(0, 1)), predict_word(start));
        sent++;
      end else begin
        case ($urandom_range(0, 3))
          0: start[31:0] = 32'hFFFF_FFFF - $urandom_range(0, 8);
          1: start = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 8);
          default: ;
        endcase
        run_len = $urandom_range(1, 12);
        for (k = 0; k < run_len; k++)
          send_counter(start + k, k == run_len - 1, predict_word(start + k));
        sent += run_len;
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      hold = gaps_on ? $urandom_range(0, 17) : 0;
      if (long_hold) begin
        hold      = LongHold;
        long_hold = 1'b0;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : word_check
    word_entry_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word with nothing pending", random_word, '0);
      end else begin
        want = pending_words.pop_front();
        if (random_word !== want.word) report_mismatch("random_word", random_word, want.word);
        if (last_out !== want.last)
          report_mismatch("last_out", word_t'(last_out), word_t'(want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    word_t key_value;
    int    phase;
    int    i;
    foreach (key_words[j]) key_words[j] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r])
      send_counter(directed_rows[r].counter, directed_rows[r].last,
                   directed_rows[r].typed ? directed_rows[r].word
                                          : predict_word(directed_rows[r].counter));
    in_valid <= 1'b0;

    for (phase = 0; phase < NumPhases; phase++) begin
      while (pending_words.size() != 0) @(posedge clk_i);
      for (i = 0; i < NumWords; i++) begin
        case (phase)
          0:       key_value = '1;
          2:       key_value = word_t'(1) << $urandom_range(0, WordW - 1);
          3:       key_value = '0;
          default: key_value = $urandom;
        endcase
        write_key_reg(cfg_idx_e'(i), key_value);
      end
      // writes to unused indexes must leave the key alone
      write_key_reg(SpareIdx6, $urandom);
      write_key_reg(SpareIdx7, $urandom);
      cfg_we <= 1'b0;
      gaps_on   = !(phase == 1 || phase == 5);
      // back-to-back sender against a long receiver hold fills the pipeline
      long_hold = (phase == 1);
      run_counters(ItemsPerPhase);
    end

    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (2 * LatencyCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/crw_pkg.sv
design/crw_load.sv
design/crw_stage.sv
design/counter_based_random_word.sv
test/tb_counter_based_random_word.sv
